// ===== rtl/clb_pkg.sv =====
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and codes for the cursor list buffer: operation codes,
// controller states and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package clb_pkg;

  localparam int MODE_W = 4;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_FWD        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_BACK       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_LAST       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_GOTO       = 4'd4;
  localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 4'd6;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_READ       = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SH_READ,
    ST_SH_WRITE,
    ST_FILL,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_INC,
    CUR_DEC,
    CUR_ZERO,
    CUR_LAST,
    CUR_POS
  } cur_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_AT_CURSOR,
    WR_AFTER_CURSOR
  } wr_op_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SHIFT,
    RD_CURSOR
  } rd_op_t;

  typedef enum logic [2:0] {
    SH_HOLD,
    SH_UP_AFTER,
    SH_UP_BEFORE,
    SH_DOWN,
    SH_STEP
  } sh_op_t;

  typedef struct packed {
    logic    capture;
    logic    err_set;
    logic    out_load;
    cur_op_t cur_op;
    cnt_op_t cnt_op;
    wr_op_t  wr_op;
    rd_op_t  rd_op;
    sh_op_t  sh_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic              full;
    logic              cur_zero;
    logic              at_last;
    logic              pos_ok;
    logic              shift_last;
  } dp_stat_t;

endpackage

// ===== rtl/clb_ctrl.sv =====
// ----------------------------------------------------------------------------
// clb_ctrl
// Controller of the cursor list buffer: sequences decode, entry shifts,
// insert write, cursor fetch and result hand-off, and drives both handshakes.
// ----------------------------------------------------------------------------
module clb_ctrl import clb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.err_set  = 1'b0;
    cmd.out_load = 1'b0;
    cmd.cur_op   = CUR_HOLD;
    cmd.cnt_op   = CNT_HOLD;
    cmd.wr_op    = WR_NONE;
    cmd.rd_op    = RD_NONE;
    cmd.sh_op    = SH_HOLD;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FETCH;
        case (stat.mode)
          MODE_FWD: begin
            if (!stat.empty && !stat.at_last) cmd.cur_op = CUR_INC;
          end
          MODE_BACK: begin
            if (!stat.empty && !stat.cur_zero) cmd.cur_op = CUR_DEC;
          end
          MODE_FIRST: cmd.cur_op = CUR_ZERO;
          MODE_LAST: begin
            if (!stat.empty) cmd.cur_op = CUR_LAST;
          end
          MODE_GOTO: begin
            if (stat.pos_ok) cmd.cur_op = CUR_POS;
            else cmd.err_set = 1'b1;
          end
          MODE_INS_AFTER: begin
            if (stat.empty) begin
              cmd.wr_op  = WR_AT_CURSOR;
              cmd.cnt_op = CNT_INC;
            end else if (stat.full) begin
              cmd.err_set = 1'b1;
            end else if (stat.at_last) begin
              state_nxt = ST_FILL;
            end else begin
              cmd.sh_op = SH_UP_AFTER;
              state_nxt = ST_SH_READ;
            end
          end
          MODE_INS_BEFORE: begin
            if (stat.cur_zero || stat.full) begin
              cmd.err_set = 1'b1;
            end else begin
              cmd.sh_op = SH_UP_BEFORE;
              state_nxt = ST_SH_READ;
            end
          end
          MODE_REMOVE: begin
            if (stat.empty) begin
              cmd.err_set = 1'b1;
            end else if (stat.at_last) begin
              if (!stat.cur_zero) cmd.cur_op = CUR_DEC;
              cmd.cnt_op = CNT_DEC;
            end else begin
              cmd.sh_op = SH_DOWN;
              state_nxt = ST_SH_READ;
            end
          end
          default: ;
        endcase
      end
      ST_SH_READ: begin
        cmd.rd_op = RD_SHIFT;
        state_nxt = ST_SH_WRITE;
      end
      ST_SH_WRITE: begin
        cmd.wr_op = WR_SHIFT;
        if (stat.shift_last) begin
          if (stat.mode == MODE_REMOVE) begin
            cmd.cnt_op = CNT_DEC;
            state_nxt  = ST_FETCH;
          end else begin
            state_nxt = ST_FILL;
          end
        end else begin
          cmd.sh_op = SH_STEP;
          state_nxt = ST_SH_READ;
        end
      end
      ST_FILL: begin
        cmd.cnt_op = CNT_INC;
        if (stat.mode == MODE_INS_BEFORE) begin
          cmd.wr_op  = WR_AT_CURSOR;
          cmd.cur_op = CUR_INC;
        end else begin
          cmd.wr_op = WR_AFTER_CURSOR;
        end
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.rd_op = RD_CURSOR;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

endmodule

// ===== rtl/clb_dpath.sv =====
// ----------------------------------------------------------------------------
// clb_dpath
// Datapath of the cursor list buffer: entry memory, count and cursor
// registers, shift pointer, captured word and result register.
// ----------------------------------------------------------------------------
module clb_dpath import clb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] out_current_value,
  output logic [POS_W-1:0]         out_cursor_position,
  output logic [CNT_W-1:0]         out_item_count,
  output logic                     out_error
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PCW = CW + POS_W;

  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] value_r;
  logic              err_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [AW-1:0]     src_r, lo_r;
  logic              up_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] mem [CAPACITY];

  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     cursor_inc;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  assign last_idx   = AW'(count_r - CW'(1));
  assign cursor_inc = AW'(cursor_r + AW'(1));

  assign stat.mode       = mode_r;
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CW'(CAPACITY));
  assign stat.cur_zero   = (cursor_r == '0);
  assign stat.at_last    = (cursor_r == last_idx);
  assign stat.pos_ok     = (PCW'(pos_r) < PCW'(count_r));
  assign stat.shift_last = up_r ? (src_r == lo_r) : (src_r == last_idx);

  // captured word and error flag
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      pos_r   <= in_position;
      value_r <= in_value;
      err_r   <= 1'b0;
    end else if (cmd.err_set) begin
      err_r <= 1'b1;
    end
  end

  always_comb begin
    unique case (cmd.cur_op)
      CUR_HOLD: cursor_nxt = cursor_r;
      CUR_INC:  cursor_nxt = cursor_inc;
      CUR_DEC:  cursor_nxt = AW'(cursor_r - AW'(1));
      CUR_ZERO: cursor_nxt = '0;
      CUR_LAST: cursor_nxt = last_idx;
      CUR_POS:  cursor_nxt = AW'(pos_r);
      default:  cursor_nxt = cursor_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: count_nxt = count_r;
      CNT_INC:  count_nxt = CW'(count_r + CW'(1));
      CNT_DEC:  count_nxt = CW'(count_r - CW'(1));
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // shift pointer: up walks down from the last entry, down walks up
  always_ff @(posedge clk) begin
    unique case (cmd.sh_op)
      SH_UP_AFTER: begin
        src_r <= last_idx;
        lo_r  <= cursor_inc;
        up_r  <= 1'b1;
      end
      SH_UP_BEFORE: begin
        src_r <= last_idx;
        lo_r  <= cursor_r;
        up_r  <= 1'b1;
      end
      SH_DOWN: begin
        src_r <= cursor_inc;
        up_r  <= 1'b0;
      end
      SH_STEP: src_r <= up_r ? AW'(src_r - AW'(1)) : AW'(src_r + AW'(1));
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cursor_r;
    wr_data = value_r;
    unique case (cmd.wr_op)
      WR_NONE:         wr_en = 1'b0;
      WR_SHIFT: begin
        wr_addr = up_r ? AW'(src_r + AW'(1)) : AW'(src_r - AW'(1));
        wr_data = rd_data_r;
      end
      WR_AT_CURSOR:    wr_addr = cursor_r;
      WR_AFTER_CURSOR: wr_addr = cursor_inc;
      default:         wr_en = 1'b0;
    endcase
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cursor_r;
    unique case (cmd.rd_op)
      RD_NONE:   rd_en = 1'b0;
      RD_SHIFT:  rd_addr = src_r;
      RD_CURSOR: rd_addr = cursor_r;
      default:   rd_en = 1'b0;
    endcase
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_current_value   <= stat.empty ? '0 : rd_data_r;
      out_cursor_position <= POS_W'(cursor_r);
      out_item_count      <= CNT_W'(count_r);
      out_error           <= err_r;
    end
  end

endmodule

// ===== rtl/cursor_list_buffer.sv =====
// ----------------------------------------------------------------------------
// cursor_list_buffer
// Fixed-capacity ordered list of signed 32-bit entries with a cursor.
//
// Input channel (in_valid / in_stall) carries one word: an operation code
// (forward, back, first, last, goto, insert after, insert before, remove,
// read), a goto position and an insert value. Every word returns one result
// word on the output channel (out_valid / out_stall): the entry at the
// cursor (zero when empty), the cursor position, the entry count and an
// error flag for refused operations.
// One word is worked on at a time; in_stall is high from acceptance until
// the result is handed to the output register. Cursor and read operations
// pass through decode, fetch and done. Inserts and removes move later
// entries through the single-port-pair entry memory, one read state and one
// write state per moved entry, and inserts add one write for the new entry;
// a remove at the first entry of a full list is the longest operation.
// The result register lets the next word be accepted while a result waits;
// a stalled receiver holds the result and blocks only the next hand-off.
// Reset empties the list and puts the cursor at zero; memory contents are
// not cleared. Outside reset no word is lost or repeated.
// ----------------------------------------------------------------------------
module cursor_list_buffer import clb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_current_value,
  output logic [POS_W-1:0]         out_cursor_position,
  output logic [CNT_W-1:0]         out_item_count,
  output logic                     out_error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  clb_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mode             (in_mode),
    .in_position         (in_position),
    .in_value            (in_value),
    .cmd                 (cmd),
    .stat                (stat),
    .out_current_value   (out_current_value),
    .out_cursor_position (out_cursor_position),
    .out_item_count      (out_item_count),
    .out_error           (out_error)
  );

endmodule

// ===== test/tb_cursor_list_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_cursor_list_buffer
// Self-checking bench for the cursor list buffer. A behavioral list with its
// own cursor and count predicts every result word as each operation word is
// accepted; a monitor compares the results in order, field by field. Stimulus
// runs a directed pass over empty-list, boundary and refusal cases, a
// fill-to-capacity and drain pass, random traffic under several idle and
// stall mixes, a long receiver hold-off and a mid-run pause.
// ----------------------------------------------------------------------------
module tb_cursor_list_buffer;
  import clb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY       = 64;
  localparam int CLK_HALF       = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 200;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
    logic                     err;
  } list_view_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_current_value;
  logic [POS_W-1:0]         out_cursor_position;
  logic [CNT_W-1:0]         out_item_count;
  logic                     out_error;

  logic signed [DATA_W-1:0] list_entries [CAPACITY];
  int                       list_count;
  int                       list_cursor;
  list_view_t               pending_views [$];
  int                       mismatch_count;
  int                       quiet_cycles;
  int                       send_idle_pct;
  int                       recv_stall_pct;
  bit                       hold_request;

  cursor_list_buffer #(.CAPACITY(CAPACITY)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_position         (in_position),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_current_value   (out_current_value),
    .out_cursor_position (out_cursor_position),
    .out_item_count      (out_item_count),
    .out_error           (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic list_view_t apply_list_op(input logic [MODE_W-1:0] mode,
                                               input logic [POS_W-1:0] pos,
                                               input logic signed [DATA_W-1:0] val);
    list_view_t v;
    logic       err;
    int         i;
    err = 1'b0;
    case (mode)
      MODE_FWD: begin
        if (list_count != 0 && list_cursor + 1 < list_count) list_cursor++;
      end
      MODE_BACK: begin
        if (list_cursor != 0) list_cursor--;
      end
      MODE_FIRST: list_cursor = 0;
      MODE_LAST: begin
        if (list_count != 0) list_cursor = list_count - 1;
      end
      MODE_GOTO: begin
        if (int'(pos) < list_count) list_cursor = int'(pos);
        else err = 1'b1;
      end
      MODE_INS_AFTER: begin
        if (list_count == 0) begin
          list_entries[0] = val;
          list_count = 1;
          list_cursor = 0;
        end else if (list_count >= CAPACITY) begin
          err = 1'b1;
        end else begin
          for (i = list_count; i > list_cursor + 1; i--) list_entries[i] = list_entries[i-1];
          list_entries[list_cursor+1] = val;
          list_count++;
        end
      end
      MODE_INS_BEFORE: begin
        if (list_cursor == 0 || list_count >= CAPACITY) begin
          err = 1'b1;
        end else begin
          for (i = list_count; i > list_cursor; i--) list_entries[i] = list_entries[i-1];
          list_entries[list_cursor] = val;
          list_count++;
          list_cursor++;
        end
      end
      MODE_REMOVE: begin
        if (list_count == 0) begin
          err = 1'b1;
        end else begin
          for (i = list_cursor; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          if (list_cursor != 0 && list_cursor == list_count - 1) list_cursor--;
          list_count--;
          if (list_count == 0) list_cursor = 0;
        end
      end
      default: ;
    endcase
    v.data     = (list_count != 0) ? list_entries[list_cursor] : '0;
    v.position = POS_W'(list_cursor);
    v.count    = CNT_W'(list_count);
    v.err      = err;
    return v;
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_views.push_back(apply_list_op(mode, pos, val));
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (list_count != 0 && $urandom_range(99) < 75) return POS_W'($urandom_range(list_count - 1));
    return POS_W'($urandom_range(CAPACITY - 1));
  endfunction

  task automatic send_random_word(input int grow_pct);
    int               r;
    logic [MODE_W-1:0] mode;
    r = $urandom_range(99);
    if (r < grow_pct)           mode = ($urandom_range(99) < 60) ? MODE_INS_AFTER : MODE_INS_BEFORE;
    else if (r < grow_pct + 15) mode = MODE_REMOVE;
    else if (r < grow_pct + 30) mode = MODE_GOTO;
    else if (r < grow_pct + 40) mode = MODE_FWD;
    else if (r < grow_pct + 50) mode = MODE_BACK;
    else if (r < grow_pct + 53) mode = MODE_FIRST;
    else if (r < grow_pct + 56) mode = MODE_LAST;
    else if (r < grow_pct + 62) mode = MODE_READ;
    else mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    send_word(mode, ($urandom_range(3) == 0) ? POS_W'($urandom) : pick_position(), pick_value());
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(MODE_FWD, '0, '0);
    send_word(MODE_BACK, '0, '0);
    send_word(MODE_FIRST, '0, '0);
    send_word(MODE_LAST, '0, '0);
    send_word(MODE_GOTO, '0, '0);
    send_word(MODE_GOTO, '1, '0);
    send_word(MODE_INS_BEFORE, '0, VAL_MAX);
    send_word(MODE_REMOVE, '0, '0);
    send_word(MODE_READ, '1, '1);
    send_word(MODE_SPARE_HI, '1, '1);
    send_word(MODE_INS_AFTER, '0, VAL_MIN);
    send_word(MODE_INS_BEFORE, '0, 32'sd5);
    send_word(MODE_INS_AFTER, '1, VAL_MAX);
    send_word(MODE_FWD, '0, '0);
    send_word(MODE_FWD, '0, '0);
    send_word(MODE_INS_BEFORE, '0, -1);
    send_word(MODE_BACK, '0, '0);
    send_word(MODE_FIRST, '0, '0);
    send_word(MODE_BACK, '0, '0);
    send_word(MODE_LAST, '0, '0);
    send_word(MODE_GOTO, 6'd3, '0);
    send_word(MODE_GOTO, '0, '0);
    send_word(MODE_REMOVE, '0, '0);
    send_word(MODE_LAST, '0, '0);
    send_word(MODE_REMOVE, '0, '0);
    send_word(MODE_SPARE_LO, '0, '0);
    wait_results_drained();
  endtask

  task automatic test_fill_and_drain();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    while (list_count < CAPACITY) begin
      send_word((list_cursor != 0 && $urandom_range(1)) ? MODE_INS_BEFORE : MODE_INS_AFTER,
                POS_W'($urandom), pick_value());
    end
    send_word(MODE_INS_AFTER, '0, VAL_MAX);
    send_word(MODE_GOTO, '1, '0);
    send_word(MODE_INS_BEFORE, '0, VAL_MIN);
    send_word(MODE_INS_AFTER, '0, VAL_MIN);
    send_word(MODE_FWD, '0, '0);
    send_word(MODE_READ, '0, '0);
    while (list_count != 0) begin
      if ($urandom_range(99) < 30) send_word(MODE_GOTO, pick_position(), pick_value());
      send_word(MODE_REMOVE, POS_W'($urandom), pick_value());
    end
    send_word(MODE_REMOVE, '0, '0);
    send_word(MODE_LAST, '0, '0);
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct,
                             input int grow_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random_word(grow_pct);
  endtask

  task automatic test_receiver_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (24) send_random_word(25);
  endtask

  task automatic test_sender_pause();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (30) send_random_word(25);
    wait_results_drained();
    repeat (30) send_random_word(20);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    list_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: value %0d pos %0d count %0d err %0b",
                   out_current_value, out_cursor_position, out_item_count, out_error);
      end else begin
        want = pending_views.pop_front();
        if (out_current_value !== want.data || out_cursor_position !== want.position ||
            out_item_count !== want.count || out_error !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     want.data, want.position, want.count, want.err, out_current_value,
                     out_cursor_position, out_item_count, out_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL cursor_list_buffer");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = '0;
    in_position    = '0;
    in_value       = '0;
    list_count     = 0;
    list_cursor    = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random(220, 0, 0, 30);
    test_random(220, 52, 0, 18);
    test_receiver_hold_off();
    test_random(220, 0, 52, 30);
    test_random(220, 24, 24, 18);
    test_sender_pause();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("PASS cursor_list_buffer");
    end else begin
      $display("FAIL cursor_list_buffer");
    end
    $finish;
  end

endmodule
